@@ hdl/gzip_header_skipper_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef GZIP_HEADER_SKIPPER_MACROS_SVH
`define GZIP_HEADER_SKIPPER_MACROS_SVH

// same-cycle implication, checked outside reset
`define GZHS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GZHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/gzhs_pkg.sv @@
`timescale 1ns / 1ps
package gzhs_pkg;

    typedef enum logic [3:0] {
        PH_FIXED   = 4'd0,
        PH_XLEN0   = 4'd1,
        PH_XLEN1   = 4'd2,
        PH_EXTRA   = 4'd3,
        PH_NAME    = 4'd4,
        PH_COMMENT = 4'd5,
        PH_HCRC    = 4'd6,
        PH_PAYLOAD = 4'd7,
        PH_ERROR   = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        ST_HEADER  = 3'd0,
        ST_PAYLOAD = 3'd1,
        ST_BAD     = 3'd2,
        ST_TRUNC   = 3'd3,
        ST_DISCARD = 3'd4
    } t_status;

    localparam logic [7:0] METHOD_DEFLATE = 8'd8;
    localparam logic [7:0] FL_RESV        = 8'hE0;
    localparam logic [4:0] FL_HCRC        = 5'h02;
    localparam logic [4:0] FL_EXTRA       = 5'h04;
    localparam logic [4:0] FL_NAME        = 5'h08;
    localparam logic [4:0] FL_COMMENT     = 5'h10;
    localparam int         POS_METHOD     = 2;
    localparam int         POS_FLAGS      = 3;
    localparam int         POS_FIXED_END  = 9;
    localparam logic [1:0] CRC_BYTES      = 2'd2;

    typedef struct packed {
        t_status     status;
        logic [7:0]  payload_byte;
        logic [31:0] position;
        logic        end_of_member;
    } t_result;

    function automatic t_phase after_comment(input logic [4:0] flags);
        return ((flags & FL_HCRC) != 5'd0) ? PH_HCRC : PH_PAYLOAD;
    endfunction

    function automatic t_phase after_name(input logic [4:0] flags);
        return ((flags & FL_COMMENT) != 5'd0) ? PH_COMMENT : after_comment(flags);
    endfunction

    function automatic t_phase after_extra(input logic [4:0] flags);
        return ((flags & FL_NAME) != 5'd0) ? PH_NAME : after_name(flags);
    endfunction

    function automatic t_phase after_fixed(input logic [4:0] flags);
        return ((flags & FL_EXTRA) != 5'd0) ? PH_XLEN0 : after_extra(flags);
    endfunction

endpackage

@@ hdl/gzip_header_skipper.sv @@
// result: the result word for an accepted input word is registered in the output stage before the master side
// throughput: one word per cycle while s_axis_tready is high, each byte takes one combinational pass of the parser
// stall: the two-entry output stage takes one more word after the receiver stops, then tready drops
// reset: i_rst_n synchronous, active low; parser returns to the fixed header, offset zero
// the parser also rearms by itself after every word marked with tlast
`timescale 1ns / 1ps
module gzip_header_skipper #(
    parameter int POSITION_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] payload_byte, [39:8] position
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    output logic        m_axis_tlast    // end_of_member
);
    import gzhs_pkg::*;
    `include "gzip_header_skipper_macros.svh"

    t_result core_result;
    t_result out_result;
    logic    accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    gzhs_parser #(
        .POSITION_BITS(POSITION_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_result (core_result)
    );

    gzhs_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_result (core_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {out_result.position, out_result.payload_byte};
    assign m_axis_tuser = out_result.status;
    assign m_axis_tlast = out_result.end_of_member;

    `GZHS_ASSERT_NEXT(a_result_follows, accept, m_axis_tvalid,
        "accepted word produced no result")

endmodule

@@ hdl/gzhs_parser.sv @@
`timescale 1ns / 1ps
module gzhs_parser #(
    parameter int POSITION_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data,
    input  logic              i_last,
    output gzhs_pkg::t_result o_result
);
    import gzhs_pkg::*;
    `include "gzip_header_skipper_macros.svh"

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    t_phase                   r_phase, n_phase;
    logic [4:0]               r_flags, n_flags;
    logic [15:0]              r_extra, n_extra;
    logic [1:0]               r_crc, n_crc;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    t_status                  status;
    logic [15:0]              extra_dec;
    logic [1:0]               crc_dec;
    logic [31:0]              pos_out;

    assign extra_dec = r_extra - 16'd1;
    assign crc_dec   = r_crc - 2'd1;

    always_comb begin
        n_phase = r_phase;
        n_flags = r_flags;
        n_extra = r_extra;
        n_crc   = r_crc;
        status  = ST_HEADER;
        case (r_phase)
            PH_FIXED: begin
                if (r_pos == POSITION_BITS'(POS_METHOD) && i_data != METHOD_DEFLATE) begin
                    status  = ST_BAD;
                    n_phase = PH_ERROR;
                end else if (r_pos == POSITION_BITS'(POS_FLAGS) &&
                             (i_data & FL_RESV) != 8'd0) begin
                    status  = ST_BAD;
                    n_phase = PH_ERROR;
                end else begin
                    if (r_pos == POSITION_BITS'(POS_FLAGS)) begin
                        n_flags = i_data[4:0];
                    end
                    if (r_pos >= POSITION_BITS'(POS_FIXED_END)) begin
                        n_phase = after_fixed(r_flags);
                    end
                end
            end
            PH_XLEN0: begin
                n_extra = {8'd0, i_data};
                n_phase = PH_XLEN1;
            end
            PH_XLEN1: begin
                n_extra = {i_data, r_extra[7:0]};
                n_phase = ({i_data, r_extra[7:0]} == 16'd0) ? after_extra(r_flags) : PH_EXTRA;
            end
            PH_EXTRA: begin
                n_extra = extra_dec;
                if (extra_dec == 16'd0) begin
                    n_phase = after_extra(r_flags);
                end
            end
            PH_NAME: begin
                if (i_data == 8'd0) begin
                    n_phase = after_name(r_flags);
                end
            end
            PH_COMMENT: begin
                if (i_data == 8'd0) begin
                    n_phase = after_comment(r_flags);
                end
            end
            PH_HCRC: begin
                n_crc = crc_dec;
                if (crc_dec == 2'd0) begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                status = ST_PAYLOAD;
            end
            default: begin
                status  = ST_DISCARD;
                n_phase = PH_ERROR;
            end
        endcase
        // crc count loads on entry to the crc section
        if (n_phase == PH_HCRC && r_phase != PH_HCRC) begin
            n_crc = CRC_BYTES;
        end
        if (i_last && status == ST_HEADER) begin
            status = ST_TRUNC;
        end
        if (i_last) begin
            n_phase = PH_FIXED;
            n_flags = 5'd0;
            n_extra = 16'd0;
            n_crc   = 2'd0;
            n_pos   = '0;
        end else if (r_pos != POS_MAX) begin
            n_pos = r_pos + POSITION_BITS'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    // clamp the offset into the 32-bit result field
    generate
        if (POSITION_BITS > 32) begin : g_pos_wide
            assign pos_out = (|r_pos[POSITION_BITS-1:32]) ? 32'hFFFF_FFFF : r_pos[31:0];
        end else begin : g_pos_narrow
            assign pos_out = 32'(r_pos);
        end
    endgenerate

    always_comb begin
        o_result.status        = status;
        o_result.payload_byte  = (status == ST_PAYLOAD) ? i_data : 8'd0;
        o_result.position      = pos_out;
        o_result.end_of_member = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIXED;
            r_flags <= 5'd0;
            r_extra <= 16'd0;
            r_crc   <= 2'd0;
            r_pos   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_extra <= n_extra;
            r_crc   <= n_crc;
            r_pos   <= n_pos;
        end
    end

    `GZHS_ASSERT_NEXT(a_rearm, i_accept && i_last, r_phase == PH_FIXED && r_pos == '0,
        "parser did not rearm after last word")
    `GZHS_ASSERT_NOW(a_extra_nonzero, r_phase == PH_EXTRA, r_extra != 16'd0,
        "extra section entered with zero count")
    `GZHS_ASSERT_NOW(a_crc_nonzero, r_phase == PH_HCRC, r_crc != 2'd0,
        "crc section entered with zero count")

endmodule

@@ hdl/gzhs_out_stage.sv @@
`timescale 1ns / 1ps
module gzhs_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gzhs_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output gzhs_pkg::t_result o_result
);
    import gzhs_pkg::*;
    `include "gzip_header_skipper_macros.svh"

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;
    logic    pop;

    assign o_ready  = !r_skid_valid;
    assign take     = i_valid && o_ready;
    assign pop      = r_out_valid && i_ready;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (pop) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (take) begin
                if (!r_out_valid || pop) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (take) begin
            if (!r_out_valid || pop) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    `GZHS_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid,
        "skid word held with empty output register")
    `GZHS_ASSERT_NEXT(a_skid_fill, take && r_out_valid && !i_ready, r_skid_valid,
        "stalled word not captured in skid register")

endmodule

@@ dv/gzip_header_skipper_tb.sv @@
`timescale 1ns / 1ps
module gzip_header_skipper_tb;
    import gzhs_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_gz_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [7:0] payload_byte, [39:8] position
    logic [2:0]  m_axis_tuser;           // [2:0] status
    logic        m_axis_tlast;           // end_of_member

    gzip_header_skipper DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    t_gz_word tx_words[$];
    t_result  expected_labels[$];
    int       words_queued = 0;
    int       words_sent = 0;
    int       labels_checked = 0;
    int       members_seen = 0;
    int       status_seen[5] = '{default: 0};
    int       fail_count = 0;
    int       tx_idle_pct = 0;
    int       rx_stall_pct = 0;
    int       hold_req = 0;

    // parser mirror
    t_phase      gz_phase = PH_FIXED;
    logic [4:0]  gz_flags = 5'd0;
    logic [15:0] gz_extra_left = 16'd0;
    logic [1:0]  gz_crc_left = 2'd0;
    logic [31:0] gz_pos = 32'd0;

    // move on to the first section after 'done' that the flags ask for
    function automatic void leave_section(input t_phase done);
        t_phase nxt;
        nxt = PH_PAYLOAD;
        if (done == PH_FIXED && (gz_flags & FL_EXTRA) != 5'd0)
            nxt = PH_XLEN0;
        else if (done <= PH_EXTRA && (gz_flags & FL_NAME) != 5'd0)
            nxt = PH_NAME;
        else if (done <= PH_NAME && (gz_flags & FL_COMMENT) != 5'd0)
            nxt = PH_COMMENT;
        else if ((gz_flags & FL_HCRC) != 5'd0)
            nxt = PH_HCRC;
        if (nxt == PH_HCRC)
            gz_crc_left = CRC_BYTES;
        gz_phase = nxt;
    endfunction

    function automatic t_result label_byte(input logic [7:0] b, input logic last);
        t_result     r;
        t_status     st;
        logic [31:0] pos;
        pos = gz_pos;
        st  = ST_HEADER;
        case (gz_phase)
            PH_FIXED: begin
                if (pos == POS_METHOD && b != METHOD_DEFLATE) begin
                    st = ST_BAD;
                    gz_phase = PH_ERROR;
                end else if (pos == POS_FLAGS && (b & FL_RESV) != 8'd0) begin
                    st = ST_BAD;
                    gz_phase = PH_ERROR;
                end else begin
                    if (pos == POS_FLAGS)
                        gz_flags = b[4:0];
                    if (pos >= POS_FIXED_END)
                        leave_section(PH_FIXED);
                end
            end
            PH_XLEN0: begin
                gz_extra_left = {8'h00, b};
                gz_phase = PH_XLEN1;
            end
            PH_XLEN1: begin
                gz_extra_left = {b, gz_extra_left[7:0]};
                if (gz_extra_left == 16'd0)
                    leave_section(PH_EXTRA);
                else
                    gz_phase = PH_EXTRA;
            end
            PH_EXTRA: begin
                gz_extra_left = gz_extra_left - 16'd1;
                if (gz_extra_left == 16'd0)
                    leave_section(PH_EXTRA);
            end
            PH_NAME: if (b == 8'd0) leave_section(PH_NAME);
            PH_COMMENT: if (b == 8'd0) leave_section(PH_COMMENT);
            PH_HCRC: begin
                gz_crc_left = gz_crc_left - 2'd1;
                if (gz_crc_left == 2'd0)
                    gz_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: st = ST_PAYLOAD;
            default: begin
                st = ST_DISCARD;
                gz_phase = PH_ERROR;
            end
        endcase
        if (last && st == ST_HEADER)
            st = ST_TRUNC;
        r.status        = st;
        r.payload_byte  = (st == ST_PAYLOAD) ? b : 8'h00;
        r.position      = pos;
        r.end_of_member = last;
        if (last) begin
            gz_phase      = PH_FIXED;
            gz_flags      = 5'd0;
            gz_extra_left = 16'd0;
            gz_crc_left   = 2'd0;
            gz_pos        = 32'd0;
        end else if (pos != 32'hFFFF_FFFF) begin
            gz_pos = pos + 32'd1;
        end
        return r;
    endfunction

    function automatic void queue_word(input logic [7:0] d, input logic l);
        t_gz_word w;
        w.data = d;
        w.last = l;
        tx_words.push_back(w);
        words_queued++;
    endfunction

    // one member; cut > 0 ends it early after that many bytes
    task automatic add_member(input logic [7:0] method, input logic [7:0] flg,
                              input logic [15:0] xlen, input int name_n,
                              input int cmt_n, input int pay_n, input int cut);
        logic [7:0] m[$];
        int         n;
        m.push_back(($urandom_range(1) != 0) ? 8'h1f : 8'($urandom_range(255)));
        m.push_back(($urandom_range(1) != 0) ? 8'h8b : 8'($urandom_range(255)));
        m.push_back(method);
        m.push_back(flg);
        for (int i = 0; i < 6; i++)
            m.push_back(8'($urandom_range(255)));
        if ((flg[4:0] & FL_EXTRA) != 5'd0) begin
            m.push_back(xlen[7:0]);
            m.push_back(xlen[15:8]);
            for (int i = 0; i < xlen; i++)
                m.push_back(8'($urandom_range(255)));
        end
        if ((flg[4:0] & FL_NAME) != 5'd0) begin
            for (int i = 0; i < name_n; i++)
                m.push_back(8'($urandom_range(1, 255)));
            m.push_back(8'h00);
        end
        if ((flg[4:0] & FL_COMMENT) != 5'd0) begin
            for (int i = 0; i < cmt_n; i++)
                m.push_back(8'($urandom_range(1, 255)));
            m.push_back(8'h00);
        end
        if ((flg[4:0] & FL_HCRC) != 5'd0) begin
            m.push_back(8'($urandom_range(255)));
            m.push_back(8'($urandom_range(255)));
        end
        for (int i = 0; i < pay_n; i++)
            m.push_back(8'($urandom_range(255)));
        n = (cut > 0 && cut < m.size()) ? cut : m.size();
        for (int i = 0; i < n; i++)
            queue_word(m[i], i == n - 1);
    endtask

    task automatic add_random_traffic(input int n_words);
        int         goal;
        int         r;
        logic [7:0] meth;
        logic [15:0] xl;
        goal = words_queued + n_words;
        while (words_queued < goal) begin
            r  = $urandom_range(99);
            xl = ($urandom_range(39) == 0) ? 16'($urandom_range(256, 262)) :
                                             16'($urandom_range(5));
            if (r < 70) begin
                add_member(METHOD_DEFLATE, 8'($urandom_range(31)), xl, $urandom_range(4),
                           $urandom_range(4), $urandom_range(1, 8), 0);
            end else if (r < 78) begin
                meth = 8'($urandom_range(255));
                if (meth == METHOD_DEFLATE)
                    meth = ~meth;
                add_member(meth, 8'($urandom_range(31)), xl, 2, 2, $urandom_range(1, 6), 0);
            end else if (r < 84) begin
                add_member(METHOD_DEFLATE,
                           8'($urandom_range(255) | (8'h20 << $urandom_range(2))),
                           xl, 2, 2, $urandom_range(1, 6), 0);
            end else if (r < 92) begin
                // member ends somewhere inside its header
                add_member(METHOD_DEFLATE, 8'($urandom_range(31)), xl, $urandom_range(4),
                           $urandom_range(4), 0, $urandom_range(1, 30));
            end else begin
                r = $urandom_range(1, 12);
                for (int i = 0; i < r; i++)
                    queue_word(8'($urandom_range(255)), i == r - 1);
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (tx_words.size() != 0 || s_axis_tvalid || expected_labels.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // sender: holds a word until taken, then maybe idles
    always @(posedge i_clk) begin : drv
        t_gz_word w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_labels.push_back(label_byte(s_axis_tdata, s_axis_tlast));
                words_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    w = tx_words.pop_front();
                    s_axis_tdata  <= w.data;
                    s_axis_tlast  <= w.last;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result word against the oldest expected label
    always @(posedge i_clk) begin : mon
        int      hold_seen;
        int      hold_left;
        t_result e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                labels_checked++;
                if (m_axis_tuser <= ST_DISCARD)
                    status_seen[m_axis_tuser]++;
                if (m_axis_tlast)
                    members_seen++;
                if (expected_labels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word: status %0d byte %02h pos %0d last %0b",
                                 m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8],
                                 m_axis_tlast);
                end else begin
                    e = expected_labels.pop_front();
                    if (m_axis_tuser != e.status || m_axis_tdata[7:0] != e.payload_byte ||
                        m_axis_tdata[39:8] != e.position ||
                        m_axis_tlast != e.end_of_member) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch at word %0d: exp status %0d byte %02h pos %0d last %0b",
                                     labels_checked, e.status, e.payload_byte, e.position,
                                     e.end_of_member);
                            $display("  got status %0d byte %02h pos %0d last %0b",
                                     m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8],
                                     m_axis_tlast);
                        end
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 60;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int tx_pct[4];
        int rx_pct[4];
        tx_pct = '{0, 81, 0, 25};
        rx_pct = '{0, 0, 81, 25};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // every optional section, empty extra field, flag bit 0 set
        add_member(METHOD_DEFLATE, 8'h1F, 16'd0, 0, 1, 1, 0);
        // bad method on a byte that also ends the member
        add_member(8'h00, 8'h00, 16'd0, 0, 0, 1, 3);
        // all reserved flag bits, then a discarded final byte
        add_member(METHOD_DEFLATE, 8'hFF, 16'd0, 0, 0, 1, 5);
        // one-byte member
        add_member(METHOD_DEFLATE, 8'h00, 16'd0, 0, 0, 1, 1);
        wait_idle();

        // long receiver hold while the sender keeps offering
        hold_req++;
        add_member(METHOD_DEFLATE, 8'h1E, 16'd3, 3, 2, 6, 0);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = tx_pct[ph];
            rx_stall_pct = rx_pct[ph];
            add_random_traffic(135);
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        $display("%0d words in %0d members: %0d header, %0d payload, %0d bad, %0d truncated,",
                 words_sent, members_seen, status_seen[ST_HEADER], status_seen[ST_PAYLOAD],
                 status_seen[ST_BAD], status_seen[ST_TRUNC]);
        $display("%0d discarded; %0d result words checked, %0d failures",
                 status_seen[ST_DISCARD], labels_checked, fail_count);
        if (fail_count == 0 && expected_labels.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
